>>> src/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants of the frustum point projection
// Widths of the fixed-point datapath and the records that travel through the
// division and fraction pipelines.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int CAM_W      = 50;  // camera coordinate, signed Q.30
  localparam int Z_W        = 50;  // divisor and remainder width
  localparam int DIV_W      = 54;  // dividend and quotient width
  localparam int F_W        = 24;  // focal length, baseline times focal
  localparam int PT_W       = 32;
  localparam int ROT_W      = 16;
  localparam int T_W        = 21;
  localparam int T_SHIFT    = 22;
  localparam int BF_SHIFT   = 30;
  localparam int QA_W       = 34;
  localparam int M_W        = 41;
  localparam int U_W        = 43;
  localparam int UR_W       = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [QA_W-1:0] QA_CAP = QA_W'(1) << 33;
  localparam logic [M_W-1:0]  M_CAP  = M_W'(1) << 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0,
    REG_ROT_ROW1,
    REG_ROT_ROW2,
    REG_TRANSLATION,
    REG_FOCAL_LENGTHS,
    REG_PRINCIPAL_POINT,
    REG_BASELINE_FOCAL,
    REG_IMAGE_SIZE
  } cfg_reg_t;

  // One item inside the divider: three lanes share the divisor z.
  typedef struct packed {
    logic [Z_W-1:0]   r_x;
    logic [Z_W-1:0]   r_y;
    logic [Z_W-1:0]   r_b;
    logic [DIV_W-1:0] q_x;
    logic [DIV_W-1:0] q_y;
    logic [DIV_W-1:0] q_b;
    logic [Z_W-1:0]   z;
    logic             neg_x;
    logic             neg_y;
    logic             z_pos;
  } div_t;

  // One item inside the fraction pipeline.
  typedef struct packed {
    logic [Z_W-1:0]   ra_x;
    logic [Z_W-1:0]   ra_y;
    logic [Z_W-1:0]   acc_x;
    logic [Z_W-1:0]   acc_y;
    logic [Z_W-1:0]   z;
    logic [DIV_W-1:0] qa_x;
    logic [DIV_W-1:0] qa_y;
    logic [DIV_W-1:0] q_b;
    logic [F_W-1:0]   fq_x;
    logic [F_W-1:0]   fq_y;
    logic             neg_x;
    logic             neg_y;
    logic             z_pos;
  } frac_t;

endpackage

>>> src/fpp_div_pipe.sv
// ----------------------------------------------------------------------------
// fpp_div_pipe: pipelined restoring divider, three lanes
// One quotient bit per stage; the lanes share the divisor of the item.
// ----------------------------------------------------------------------------
module fpp_div_pipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  fpp_pkg::div_t din,
  output logic          out_valid,
  output fpp_pkg::div_t dout
);
  import fpp_pkg::*;

  div_t             pipe [DIV_W];
  div_t             nxt  [DIV_W];
  logic [DIV_W-1:0] vld;

  // Shift the next dividend bit into the remainder and subtract if it fits.
  function automatic logic [Z_W+DIV_W-1:0] div_bit(input logic [Z_W-1:0]   r,
                                                   input logic [DIV_W-1:0] q,
                                                   input logic [Z_W-1:0]   z);
    logic [Z_W:0] t;
    logic [Z_W:0] d;
    t = {r, q[DIV_W-1]};
    d = t - {1'b0, z};
    if (t >= {1'b0, z}) begin
      return {d[Z_W-1:0], q[DIV_W-2:0], 1'b1};
    end
    return {t[Z_W-1:0], q[DIV_W-2:0], 1'b0};
  endfunction

  always_comb begin
    for (int k = 0; k < DIV_W; k++) begin
      nxt[k] = (k == 0) ? din : pipe[(k == 0) ? 0 : k - 1];
      {nxt[k].r_x, nxt[k].q_x} = div_bit(nxt[k].r_x, nxt[k].q_x, nxt[k].z);
      {nxt[k].r_y, nxt[k].q_y} = div_bit(nxt[k].r_y, nxt[k].q_y, nxt[k].z);
      {nxt[k].r_b, nxt[k].q_b} = div_bit(nxt[k].r_b, nxt[k].q_b, nxt[k].z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_W; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_W-2:0], in_valid};
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign dout      = pipe[DIV_W-1];

endmodule

>>> src/fpp_frac_pipe.sv
// ----------------------------------------------------------------------------
// fpp_frac_pipe: fraction of the scaled quotient
// Forms floor(f * ra / z) one focal-length bit per stage for both lanes.
// ----------------------------------------------------------------------------
module fpp_frac_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [fpp_pkg::F_W-1:0] fx,
  input  logic [fpp_pkg::F_W-1:0] fy,
  input  logic                   in_valid,
  input  fpp_pkg::frac_t         din,
  output logic                   out_valid,
  output fpp_pkg::frac_t         dout
);
  import fpp_pkg::*;

  frac_t          pipe [F_W];
  frac_t          nxt  [F_W];
  logic [F_W-1:0] vld;

  // acc' = (2 acc + b ra) mod z, q' = 2 q + floor((2 acc + b ra) / z).
  function automatic logic [Z_W+F_W-1:0] frac_bit(input logic [Z_W-1:0] acc,
                                                   input logic [F_W-1:0] q,
                                                   input logic [Z_W-1:0] ra,
                                                   input logic [Z_W-1:0] z,
                                                   input logic           b);
    logic [Z_W+1:0] s;
    logic [Z_W+1:0] d1;
    logic [Z_W+1:0] d2;
    s  = {1'b0, acc, 1'b0} + (b ? {2'b00, ra} : '0);
    d1 = s - {2'b00, z};
    d2 = s - {1'b0, z, 1'b0};
    if (s >= {1'b0, z, 1'b0}) begin
      return {d2[Z_W-1:0], {q[F_W-2:0], 1'b0} + F_W'(2)};
    end else if (s >= {2'b00, z}) begin
      return {d1[Z_W-1:0], {q[F_W-2:0], 1'b1}};
    end
    return {s[Z_W-1:0], {q[F_W-2:0], 1'b0}};
  endfunction

  always_comb begin
    for (int k = 0; k < F_W; k++) begin
      nxt[k] = (k == 0) ? din : pipe[(k == 0) ? 0 : k - 1];
      {nxt[k].acc_x, nxt[k].fq_x} = frac_bit(nxt[k].acc_x, nxt[k].fq_x, nxt[k].ra_x,
                                             nxt[k].z, fx[F_W-1-k]);
      {nxt[k].acc_y, nxt[k].fq_y} = frac_bit(nxt[k].acc_y, nxt[k].fq_y, nxt[k].ra_y,
                                             nxt[k].z, fy[F_W-1-k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < F_W; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[F_W-2:0], in_valid};
    end
  end

  assign out_valid = vld[F_W-1];
  assign dout      = pipe[F_W-1];

endmodule

>>> src/frustum_point_projection.sv
// ----------------------------------------------------------------------------
// frustum_point_projection: pinhole projection with a view-frustum test
// Moves world points into camera coordinates, projects them and flags those
// that land inside the image, with the predicted right-image column.
// ----------------------------------------------------------------------------
// The block takes one world point per beat and gives one result beat per
// point, in order, and it accepts a new point in every cycle while the skid
// register is empty. A point passes 86 pipeline stages (rotation products,
// sums, sign split, a 54-stage restoring divider that serves both image
// axes and the stereo term at once, a 24-stage fraction pipeline for the
// focal scaling, then scaling, offset, bounds test and saturation); the
// first stage captures it at the edge that accepts it, and the output
// register takes its result from the last of those stages. The output
// register is backed by a skid register, so a result that waits does not
// stop the input; the input stops only while the skid register is full.
// Results whose depth is not positive or whose projection lies outside
// 0..width and 0..height carry in_view low and zero coordinates. The
// configuration registers are written through the cfg port, which is always
// ready, and should only be written while no point is in flight.
// ----------------------------------------------------------------------------
module frustum_point_projection (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // World points.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [95:0]                      s_axis_tdata,  // point_x, point_y, point_z
  // Projections.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [95:0]                      m_axis_tdata,  // proj_u, proj_v, proj_u_right
  output logic                             m_axis_tuser   // in_view
);
  import fpp_pkg::*;

  typedef struct packed {
    logic                  in_view;
    logic [PT_W-1:0]       u;
    logic [PT_W-1:0]       v;
    logic [PT_W-1:0]       ur;
  } res_t;

  // Configuration registers.
  logic [47:0]      rot [3];
  logic [62:0]      translation;
  logic [47:0]      focal_lengths;
  logic [47:0]      principal_point;
  logic [F_W-1:0]   baseline_focal;
  logic [31:0]      image_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]          <= 48'd16384;
      rot[1]          <= 48'd1073741824;
      rot[2]          <= 48'd70368744177664;
      translation     <= '0;
      focal_lengths   <= '0;
      principal_point <= '0;
      baseline_focal  <= '0;
      image_size      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_ROW0:        rot[0]          <= cfg_data[47:0];
        REG_ROT_ROW1:        rot[1]          <= cfg_data[47:0];
        REG_ROT_ROW2:        rot[2]          <= cfg_data[47:0];
        REG_TRANSLATION:     translation     <= cfg_data[62:0];
        REG_FOCAL_LENGTHS:   focal_lengths   <= cfg_data[47:0];
        REG_PRINCIPAL_POINT: principal_point <= cfg_data[47:0];
        REG_BASELINE_FOCAL:  baseline_focal  <= cfg_data[F_W-1:0];
        REG_IMAGE_SIZE:      image_size      <= cfg_data[31:0];
        default:             ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic [F_W-1:0] fx, fy, cx, cy;
  assign fx = focal_lengths[23:0];
  assign fy = focal_lengths[47:24];
  assign cx = principal_point[23:0];
  assign cy = principal_point[47:24];

  // The whole pipeline moves together unless the skid register is occupied.
  logic skid_valid;
  logic en;
  assign en            = !skid_valid;
  assign s_axis_tready = !skid_valid;

  // Stage A: input capture.
  logic                   a_vld;
  logic signed [PT_W-1:0] pt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pt[j] <= $signed(s_axis_tdata[PT_W*j +: PT_W]);
      end
    end
  end

  // Stage B: the nine rotation products.
  logic                 b_vld;
  logic signed [47:0]   prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= $signed(rot[i][ROT_W*j +: ROT_W]) * pt[j];
        end
      end
    end
  end

  // Stage C: camera coordinates in Q.30, translation scaled up to match.
  logic                    c_vld;
  logic signed [CAM_W-1:0] cam [3];
  logic signed [CAM_W-1:0] tsh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsh[i] = $signed({{(CAM_W-T_W-T_SHIFT){translation[T_W*i+T_W-1]}},
                        translation[T_W*i +: T_W], {T_SHIFT{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cam[i] <= prod[i][0] + prod[i][1] + prod[i][2] + tsh[i];
      end
    end
  end

  // Stage D: magnitudes and signs, loaded into the divider record.
  logic            d_vld;
  div_t            d_item;
  div_t            d_next;
  logic [CAM_W-1:0] mag_x, mag_y;

  always_comb begin
    mag_x = cam[0][CAM_W-1] ? CAM_W'(-cam[0]) : CAM_W'(cam[0]);
    mag_y = cam[1][CAM_W-1] ? CAM_W'(-cam[1]) : CAM_W'(cam[1]);
    d_next.r_x   = '0;
    d_next.r_y   = '0;
    d_next.r_b   = '0;
    d_next.q_x   = DIV_W'(mag_x);
    d_next.q_y   = DIV_W'(mag_y);
    d_next.q_b   = {baseline_focal, {BF_SHIFT{1'b0}}};
    d_next.z     = cam[2];
    d_next.neg_x = cam[0][CAM_W-1];
    d_next.neg_y = cam[1][CAM_W-1];
    d_next.z_pos = !cam[2][CAM_W-1] && (cam[2] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_item <= d_next;
    end
  end

  // Integer quotients and remainders of |x|/z, |y|/z and (baseline times focal)/z.
  logic  dv_vld;
  div_t  dv_item;
  frac_t fr_in;
  logic  fr_vld;
  frac_t fr_item;

  fpp_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_vld),
    .din       (d_item),
    .out_valid (dv_vld),
    .dout      (dv_item)
  );

  always_comb begin
    fr_in.ra_x  = dv_item.r_x;
    fr_in.ra_y  = dv_item.r_y;
    fr_in.acc_x = '0;
    fr_in.acc_y = '0;
    fr_in.z     = dv_item.z;
    fr_in.qa_x  = dv_item.q_x;
    fr_in.qa_y  = dv_item.q_y;
    fr_in.q_b   = dv_item.q_b;
    fr_in.fq_x  = '0;
    fr_in.fq_y  = '0;
    fr_in.neg_x = dv_item.neg_x;
    fr_in.neg_y = dv_item.neg_y;
    fr_in.z_pos = dv_item.z_pos;
  end

  // Focal scaling of the remainders.
  fpp_frac_pipe u_frac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .fx        (fx),
    .fy        (fy),
    .in_valid  (dv_vld),
    .din       (fr_in),
    .out_valid (fr_vld),
    .dout      (fr_item)
  );

  // Stage M: integer part times focal length, integer part capped first.
  logic                  m_vld;
  logic [QA_W+F_W-1:0]   m_px, m_py;
  logic [F_W-1:0]        m_fqx, m_fqy;
  logic                  m_negx, m_negy, m_zpos;
  logic [DIV_W-1:0]      m_qb;
  logic [QA_W-1:0]       qcap_x, qcap_y;

  assign qcap_x = (fr_item.qa_x > DIV_W'(QA_CAP)) ? QA_CAP : fr_item.qa_x[QA_W-1:0];
  assign qcap_y = (fr_item.qa_y > DIV_W'(QA_CAP)) ? QA_CAP : fr_item.qa_y[QA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= fr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px   <= qcap_x * fx;
      m_py   <= qcap_y * fy;
      m_fqx  <= fr_item.fq_x;
      m_fqy  <= fr_item.fq_y;
      m_negx <= fr_item.neg_x;
      m_negy <= fr_item.neg_y;
      m_zpos <= fr_item.z_pos;
      m_qb   <= fr_item.q_b;
    end
  end

  // Stage N: add the fraction and cap the magnitude.
  logic                  n_vld;
  logic [M_W-1:0]        n_mx, n_my;
  logic                  n_negx, n_negy, n_zpos;
  logic [DIV_W-1:0]      n_qb;
  logic [QA_W+F_W:0]     sum_x, sum_y;

  assign sum_x = {1'b0, m_px} + (QA_W+F_W+1)'(m_fqx);
  assign sum_y = {1'b0, m_py} + (QA_W+F_W+1)'(m_fqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (en) begin
      n_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_mx   <= (sum_x > (QA_W+F_W+1)'(M_CAP)) ? M_CAP : sum_x[M_W-1:0];
      n_my   <= (sum_y > (QA_W+F_W+1)'(M_CAP)) ? M_CAP : sum_y[M_W-1:0];
      n_negx <= m_negx;
      n_negy <= m_negy;
      n_zpos <= m_zpos;
      n_qb   <= m_qb;
    end
  end

  // Stage O: sign, principal point and the bounds test.
  logic                  o_vld;
  logic signed [U_W-1:0] o_u, o_v;
  logic                  o_vis;
  logic [DIV_W-1:0]      o_qb;
  logic signed [U_W-1:0] su, sv, mx_s, my_s;

  always_comb begin
    mx_s = $signed({2'b00, n_mx});
    my_s = $signed({2'b00, n_my});
    su   = (n_negx ? -mx_s : mx_s) + $signed(U_W'(cx));
    sv   = (n_negy ? -my_s : my_s) + $signed(U_W'(cy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_u   <= su;
      o_v   <= sv;
      o_qb  <= n_qb;
      o_vis <= n_zpos && !su[U_W-1] && !sv[U_W-1]
               && (su[U_W-2:0] <= (U_W-1)'({image_size[15:0], 8'd0}))
               && (sv[U_W-2:0] <= (U_W-1)'({image_size[31:16], 8'd0}));
    end
  end

  // Stage P: right column and saturation.
  localparam logic signed [UR_W-1:0] SAT_MAX = UR_W'(64'sd2147483647);
  localparam logic signed [UR_W-1:0] SAT_MIN = UR_W'(-64'sd2147483648);

  function automatic logic [PT_W-1:0] sat32(input logic signed [UR_W-1:0] a);
    if (a > SAT_MAX) begin
      return PT_W'(SAT_MAX);
    end else if (a < SAT_MIN) begin
      return PT_W'(SAT_MIN);
    end
    return a[PT_W-1:0];
  endfunction

  logic                   p_vld;
  res_t                   p_res;
  logic signed [UR_W-1:0] ue, ve, ure;

  always_comb begin
    ue  = UR_W'(o_u);
    ve  = UR_W'(o_v);
    ure = ue - $signed({2'b00, o_qb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= o_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_res.in_view <= o_vis;
      p_res.u       <= o_vis ? sat32(ue)  : '0;
      p_res.v       <= o_vis ? sat32(ve)  : '0;
      p_res.ur      <= o_vis ? sat32(ure) : '0;
    end
  end

  // Output register with a skid register behind it.
  logic leave;
  logic out_valid;
  res_t out_res;
  res_t skid_res;

  assign leave = en && p_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (leave) begin
        out_res <= p_res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (leave) begin
        out_res   <= p_res;
        out_valid <= 1'b1;
      end
    end else if (leave) begin
      skid_res   <= p_res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.in_view;
  assign m_axis_tdata  = {out_res.ur, out_res.v, out_res.u};

  // The skid register is only ever filled behind a held output beat.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register full while output is empty");

  assert property (@(posedge clk) disable iff (rst)
                   $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid register filled without an output stall");

  // Points out of view carry zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out-of-view result with nonzero coordinates");

endmodule
